### sv/piecewise_linear_color_ramp_top_assert.svh
// assertion macros for the color ramp pipeline
`ifndef PIECEWISE_LINEAR_COLOR_RAMP_TOP_ASSERT_SVH
`define PIECEWISE_LINEAR_COLOR_RAMP_TOP_ASSERT_SVH

// same-cycle implication
`define PLCR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("plcr assertion failed");

// next-cycle implication
`define PLCR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("plcr assertion failed");

`endif

### sv/plcr_pkg.sv
package plcr_pkg;

  localparam int ENTRIES   = 32;
  localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W     = $clog2(ENTRIES + 1);
  localparam int CMP_W     = (CNT_W > 6) ? CNT_W : 6;
  localparam int GRP       = 8;
  localparam int NGRP      = (ENTRIES + GRP - 1) / GRP;
  localparam int DIV_STEPS = 8;
  localparam int CFG_W     = 24;

  localparam logic [1:0] REG_SCALE  = 2'd0;
  localparam logic [1:0] REG_OFFSET = 2'd1;
  localparam logic [1:0] REG_COUNT  = 2'd2;

  localparam logic KIND_LOOKUP = 1'b0;
  localparam logic KIND_LOAD   = 1'b1;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] sample;
    logic [4:0]         entry_index;
    logic signed [23:0] entry_key;
    logic [31:0]        first_color;
    logic [31:0]        second_color;
    logic               has_second;
  } in_t;

  typedef struct packed {
    logic [31:0] pixel_color;
    logic        table_empty;
  } out_t;

  typedef struct packed {
    logic signed [23:0] key;
    logic [31:0]        start_color;
    logic [31:0]        end_color;
    logic               has_end;
  } entry_t;

endpackage

### sv/piecewise_linear_color_ramp_top.sv
// piecewise linear color ramp
// in channel (in_valid/in_ready/in_data): one transaction is either a lookup
// of a sample or a load of one breakpoint entry into the table.
// out channel (out_valid/out_ready/out_data): one transaction per lookup,
// none per load, in the order the lookups were accepted.
// cfg port (cfg_we/cfg_index/cfg_wdata): scale, offset and entry count,
// which the user must write only while the block is idle; the block does not enforce it.
// throughput: one transaction per cycle unless the receiver stalls; the
// pipeline holds up to 17 of them. a lookup passes in order through the
// input register, multiply, offset and saturate, key compare, index
// select, table read, differences, blend products, divider setup, then
// one stage per quotient bit of the 8-bit rounding divider.
// a load writes the key registers at the compare stage and the color
// memory at the read stage, so lookups see loads in transaction order.
// reset (synchronous, active low) clears all stage valids and restores
// the configuration registers; the table holds no defined values until
// it is loaded.
// when the receiver stalls, the whole pipeline holds and in_ready drops;
// nothing is lost or repeated.
`include "piecewise_linear_color_ramp_top_assert.svh"

module piecewise_linear_color_ramp_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  plcr_pkg::in_t              in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output plcr_pkg::out_t             out_data,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [plcr_pkg::CFG_W-1:0] cfg_wdata
);
  import plcr_pkg::*;

  logic signed [15:0] scale_r;
  logic signed [23:0] offset_r;
  logic [5:0]         count_r;

  logic adv;

  logic [5:1] lk_r;
  logic [5:1] ld_r;
  in_t        pay_r [1:5];

  logic signed [31:0] prod_r;
  logic signed [23:0] v3_r, v4_r, v5_r, v6_r;
  logic signed [32:0] sum_c;
  logic signed [23:0] sat_c;

  logic signed [23:0] key_r [ENTRIES];
  logic [NGRP*GRP-1:0] gt_c;
  logic [NGRP-1:0]     gf_c, gfound_r;
  logic [2:0]          gs_c [NGRP];
  logic [2:0]          gsub_r [NGRP];
  logic [CMP_W-1:0]    cnt_ext;
  logic [CNT_W-1:0]    cnt_c, cnt4_r, cm1_c;

  logic             found_c, interp_c;
  logic [IDX_W-1:0] idx_c, lo_c, hi_c;
  logic [IDX_W-1:0] lo5_r, hi5_r;
  logic             interp5_r, empty5_r;

  entry_t mem [ENTRIES];
  entry_t lo6_r, hi6_r;
  logic   lk6_r, interp6_r, empty6_r;

  logic [23:0]      num_c, dn_c, den_c;
  logic [31:0]      c1_c, c2_c;
  logic [23:0]      num7_r, dn7_r, den7_r;
  logic [3:0][7:0]  c17_r, c27_r;
  logic             lk7_r, empty7_r;

  logic [3:0][31:0] tot8_r;
  logic [23:0]      den8_r;
  logic             lk8_r, empty8_r;

  logic [3:0][33:0] rem_r [DIV_STEPS+1];
  logic [3:0][7:0]  q_r   [DIV_STEPS+1];
  logic [24:0]      dd_r  [DIV_STEPS+1];
  logic [DIV_STEPS:0] dv_r, de_r;
  logic [3:0][33:0] rem_nxt [1:DIV_STEPS];
  logic [3:0][7:0]  q_nxt   [1:DIV_STEPS];
  logic             rem_ok_c;

  assign adv      = !dv_r[DIV_STEPS] || out_ready;
  assign in_ready = adv;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r  <= 16'sd256;
      offset_r <= '0;
      count_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCALE:  scale_r  <= cfg_wdata[15:0];
        REG_OFFSET: offset_r <= cfg_wdata[23:0];
        REG_COUNT:  count_r  <= cfg_wdata[5:0];
        default: ;
      endcase
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lk_r  <= '0;
      ld_r  <= '0;
      lk6_r <= 1'b0;
      lk7_r <= 1'b0;
      lk8_r <= 1'b0;
      dv_r  <= '0;
    end else if (adv) begin
      lk_r[1] <= in_valid && (in_data.kind == KIND_LOOKUP);
      ld_r[1] <= in_valid && (in_data.kind == KIND_LOAD);
      lk_r[5:2] <= lk_r[4:1];
      ld_r[5:2] <= ld_r[4:1];
      lk6_r <= lk_r[5];
      lk7_r <= lk6_r;
      lk8_r <= lk7_r;
      dv_r  <= {dv_r[DIV_STEPS-1:0], lk8_r};
    end
  end

  // scale, offset and saturation
  always_comb begin
    sum_c = 33'(prod_r) + 33'(offset_r);
    if (sum_c > 33'sd8388607) begin
      sat_c = 24'sh7fffff;
    end else if (sum_c < -33'sd8388608) begin
      sat_c = 24'sh800000;
    end else begin
      sat_c = sum_c[23:0];
    end
  end

  // key compare and per-group first match
  always_comb begin
    cnt_ext = CMP_W'(count_r);
    cnt_c   = (cnt_ext > CMP_W'(ENTRIES)) ? CNT_W'(ENTRIES) : cnt_ext[CNT_W-1:0];
    for (int j = 0; j < NGRP*GRP; j++) begin
      if (j < ENTRIES) begin
        gt_c[j] = (CMP_W'(j) < CMP_W'(cnt_c)) && (v3_r < key_r[IDX_W'(j)]);
      end else begin
        gt_c[j] = 1'b0;
      end
    end
    for (int g = 0; g < NGRP; g++) begin
      gf_c[g] = 1'b0;
      gs_c[g] = '0;
      for (int k = GRP-1; k >= 0; k--) begin
        if (gt_c[g*GRP+k]) begin
          gf_c[g] = 1'b1;
          gs_c[g] = 3'(k);
        end
      end
    end
  end

  // segment select
  always_comb begin
    found_c = 1'b0;
    idx_c   = '0;
    for (int g = NGRP-1; g >= 0; g--) begin
      if (gfound_r[g]) begin
        found_c = 1'b1;
        idx_c   = IDX_W'(g*GRP + int'(gsub_r[g]));
      end
    end
    cm1_c    = cnt4_r - CNT_W'(1);
    interp_c = found_c && (idx_c != '0);
    hi_c     = idx_c;
    if (!found_c) begin
      lo_c = cm1_c[IDX_W-1:0];
    end else if (idx_c == '0) begin
      lo_c = '0;
    end else begin
      lo_c = idx_c - IDX_W'(1);
    end
  end

  // differences and end colors
  always_comb begin
    c1_c = lo6_r.start_color;
    if (interp6_r) begin
      num_c = 24'(25'(v6_r) - 25'(lo6_r.key));
      dn_c  = 24'(25'(hi6_r.key) - 25'(v6_r));
      den_c = 24'(25'(hi6_r.key) - 25'(lo6_r.key));
      c2_c  = lo6_r.has_end ? lo6_r.end_color : hi6_r.start_color;
    end else begin
      num_c = '0;
      dn_c  = 24'd1;
      den_c = 24'd1;
      c2_c  = lo6_r.start_color;
    end
  end

  // restoring divider, one quotient bit per stage
  always_comb begin
    for (int s = 1; s <= DIV_STEPS; s++) begin
      for (int ch = 0; ch < 4; ch++) begin
        rem_nxt[s][ch] = rem_r[s-1][ch];
        q_nxt[s][ch]   = q_r[s-1][ch];
        if (rem_r[s-1][ch] >= (34'(dd_r[s-1]) << (DIV_STEPS - s))) begin
          rem_nxt[s][ch] = rem_r[s-1][ch] - (34'(dd_r[s-1]) << (DIV_STEPS - s));
          q_nxt[s][ch][DIV_STEPS - s] = 1'b1;
        end
      end
    end
  end

  // final remainders below the divisor
  always_comb begin
    rem_ok_c = 1'b1;
    for (int ch = 0; ch < 4; ch++) begin
      if (rem_r[DIV_STEPS][ch] >= 34'(dd_r[DIV_STEPS])) begin
        rem_ok_c = 1'b0;
      end
    end
  end

  // key registers, written by a load at the compare stage
  always_ff @(posedge clk) begin
    if (adv && ld_r[3] && (int'(pay_r[3].entry_index) < ENTRIES)) begin
      key_r[IDX_W'(pay_r[3].entry_index)] <= pay_r[3].entry_key;
    end
  end

  // color memory, written by a load at the read stage
  always_ff @(posedge clk) begin
    if (adv) begin
      if (ld_r[5] && (int'(pay_r[5].entry_index) < ENTRIES)) begin
        mem[IDX_W'(pay_r[5].entry_index)] <= '{key:         pay_r[5].entry_key,
                                               start_color: pay_r[5].first_color,
                                               end_color:   pay_r[5].second_color,
                                               has_end:     pay_r[5].has_second};
      end
      lo6_r <= mem[lo5_r];
      hi6_r <= mem[hi5_r];
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (adv) begin
      pay_r[1] <= in_data;
      for (int p = 2; p <= 5; p++) begin
        pay_r[p] <= pay_r[p-1];
      end
      prod_r <= 32'(pay_r[1].sample) * 32'(scale_r);
      v3_r   <= sat_c;

      v4_r     <= v3_r;
      cnt4_r   <= cnt_c;
      gfound_r <= gf_c;
      for (int g = 0; g < NGRP; g++) begin
        gsub_r[g] <= gs_c[g];
      end

      v5_r      <= v4_r;
      lo5_r     <= lo_c;
      hi5_r     <= hi_c;
      interp5_r <= interp_c;
      empty5_r  <= (cnt4_r == '0);

      v6_r      <= v5_r;
      interp6_r <= interp5_r;
      empty6_r  <= empty5_r;

      num7_r   <= num_c;
      dn7_r    <= dn_c;
      den7_r   <= den_c;
      c17_r    <= c1_c;
      c27_r    <= c2_c;
      empty7_r <= empty6_r;

      for (int ch = 0; ch < 4; ch++) begin
        tot8_r[ch] <= 32'(c17_r[ch]) * 32'(dn7_r) + 32'(c27_r[ch]) * 32'(num7_r);
      end
      den8_r   <= den7_r;
      empty8_r <= empty7_r;

      for (int ch = 0; ch < 4; ch++) begin
        rem_r[0][ch] <= {1'b0, tot8_r[ch], 1'b0} + 34'(den8_r);
        q_r[0][ch]   <= '0;
      end
      dd_r[0] <= {den8_r, 1'b0};
      de_r[0] <= empty8_r;
      for (int s = 1; s <= DIV_STEPS; s++) begin
        rem_r[s] <= rem_nxt[s];
        q_r[s]   <= q_nxt[s];
        dd_r[s]  <= dd_r[s-1];
        de_r[s]  <= de_r[s-1];
      end
    end
  end

  assign out_valid            = dv_r[DIV_STEPS];
  assign out_data.pixel_color = de_r[DIV_STEPS] ? 32'd0 : q_r[DIV_STEPS];
  assign out_data.table_empty = de_r[DIV_STEPS];

  `PLCR_ASSERT_IMPL(a_den_nonzero, lk7_r, den7_r != '0)
  `PLCR_ASSERT_IMPL(a_interp_addr, lk_r[5] && interp5_r, 32'(hi5_r) == 32'(lo5_r) + 32'd1)
  `PLCR_ASSERT_IMPL(a_rem_below_div, dv_r[DIV_STEPS] && !de_r[DIV_STEPS], rem_ok_c)
  `PLCR_ASSERT_IMPL(a_empty_zero, out_valid && out_data.table_empty, out_data.pixel_color == '0)
  `PLCR_ASSERT_NEXT(a_blend_to_div, lk8_r && adv, dv_r[0])

endmodule
